// ===== rtl/core/stack_op_engine_macros.svh =====
// ----------------------------------------------------------------------------
// stack_op_engine assertion macros
// Shorthand for the clocked checks used in the stack engine.
// ----------------------------------------------------------------------------
`ifndef STACK_OP_ENGINE_MACROS_SVH
`define STACK_OP_ENGINE_MACROS_SVH

// same-cycle implication, quiet during reset
`define SOE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define SOE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/soe_pkg.sv =====
// ----------------------------------------------------------------------------
// soe_pkg
// Sizes, operation codes and status codes of the stack operation engine.
// ----------------------------------------------------------------------------
package soe_pkg;

  localparam int DEPTH  = 16;
  localparam int WIDTH  = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = $clog2(DEPTH);

  typedef logic [WIDTH-1:0]  elem_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_MAX  = 3'd1,
    OP_MIN  = 3'd2,
    OP_OVER = 3'd3,
    OP_ROT  = 3'd4,
    OP_SWAP = 3'd5,
    OP_DROP = 3'd6,
    OP_READ = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

endpackage

// ===== rtl/core/stack_op_engine.sv =====
// ----------------------------------------------------------------------------
// stack_op_engine
// Bounded signed data stack held in a RAM, one operation per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The engine reads the
// top three entries from the stack RAM one per cycle, works out the new
// stack, then writes back up to three entries one per cycle through the single
// write port. done pulses for one cycle with the result in the cycle after the
// last write, or straight from the calculate step when nothing is written, and
// a new request may be given in that same cycle. The result cannot be held
// off; the receiver must take it in the cycle done is high. The RAM needs no
// clearing after reset.
module stack_op_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              op,
  input  logic signed [31:0]      operand_value,
  output logic                    done,
  output logic signed [31:0]      top_value,
  output logic                    top_valid,
  output logic [4:0]              depth_now,
  output logic [1:0]              status
);

  import soe_pkg::*;

  `include "stack_op_engine_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CALC,
    S_WR
  } state_t;

  state_t  state;
  op_t     op_q;
  elem_t   opnd_q;
  cnt_t    count;
  elem_t   a;
  elem_t   b;
  addr_t   wr_addr [3];
  elem_t   wr_data [3];
  logic [1:0] wr_num;
  logic [1:0] wr_idx;
  cnt_t    count_q;
  status_t status_q;
  elem_t   top_q;

  logic    ram_we;
  addr_t   ram_raddr;
  elem_t   ram_rdata;

  // next-state values worked out in the calculate step
  cnt_t    calc_count;
  status_t calc_status;
  elem_t   calc_top;
  elem_t   calc_sel;
  logic [1:0] calc_num;
  addr_t   calc_addr [3];
  elem_t   calc_data [3];
  logic    has1;
  logic    has2;
  logic    has3;
  logic    full;

  assign busy   = (state != S_IDLE);
  assign ram_we = (state == S_WR);

  always_comb begin
    case (state)
      S_RD0:   ram_raddr = addr_t'(count - cnt_t'(1));
      S_RD1:   ram_raddr = addr_t'(count - cnt_t'(2));
      S_RD2:   ram_raddr = addr_t'(count - cnt_t'(3));
      default: ram_raddr = '0;
    endcase
  end

  soe_ram #(
    .DATA_W (WIDTH),
    .DEPTH  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr[wr_idx]),
    .wdata (wr_data[wr_idx]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a = top, b = second, ram_rdata = third (valid in S_CALC)
  always_comb begin
    has1        = (count != '0);
    has2        = (count >= cnt_t'(2));
    has3        = (count >= cnt_t'(3));
    full        = (count == cnt_t'(DEPTH));
    calc_count  = count;
    calc_status = ST_OK;
    calc_top    = a;
    calc_num    = 2'd0;
    calc_sel    = ($signed(a) > $signed(b)) ? a : b;
    for (int i = 0; i < 3; i++) begin
      calc_addr[i] = '0;
      calc_data[i] = '0;
    end
    case (op_q)
      OP_PUSH: begin
        if (full) begin
          calc_status = ST_OVER;
        end else begin
          calc_addr[0] = addr_t'(count);
          calc_data[0] = opnd_q;
          calc_num     = 2'd1;
          calc_count   = count + cnt_t'(1);
          calc_top     = opnd_q;
        end
      end
      OP_MAX, OP_MIN: begin
        if (!has2) begin
          calc_status = ST_UNDER;
        end else begin
          if (op_q == OP_MIN) begin
            calc_sel = ($signed(a) > $signed(b)) ? b : a;
          end
          calc_addr[0] = addr_t'(count - cnt_t'(2));
          calc_data[0] = calc_sel;
          calc_num     = 2'd1;
          calc_count   = count - cnt_t'(1);
          calc_top     = calc_sel;
        end
      end
      OP_OVER: begin
        if (!has2) begin
          calc_status = ST_UNDER;
        end else if (full) begin
          calc_status = ST_OVER;
        end else begin
          calc_addr[0] = addr_t'(count);
          calc_data[0] = b;
          calc_num     = 2'd1;
          calc_count   = count + cnt_t'(1);
          calc_top     = b;
        end
      end
      OP_ROT: begin
        if (!has3) begin
          calc_status = ST_UNDER;
        end else begin
          calc_addr[0] = addr_t'(count - cnt_t'(3));
          calc_data[0] = b;
          calc_addr[1] = addr_t'(count - cnt_t'(2));
          calc_data[1] = a;
          calc_addr[2] = addr_t'(count - cnt_t'(1));
          calc_data[2] = ram_rdata;
          calc_num     = 2'd3;
          calc_top     = ram_rdata;
        end
      end
      OP_SWAP: begin
        if (!has2) begin
          calc_status = ST_UNDER;
        end else begin
          calc_addr[0] = addr_t'(count - cnt_t'(1));
          calc_data[0] = b;
          calc_addr[1] = addr_t'(count - cnt_t'(2));
          calc_data[1] = a;
          calc_num     = 2'd2;
          calc_top     = b;
        end
      end
      OP_DROP: begin
        if (!has1) begin
          calc_status = ST_UNDER;
        end else begin
          calc_count = count - cnt_t'(1);
          calc_top   = b;
        end
      end
      default: begin
        if (!has1) begin
          calc_status = ST_UNDER;
        end
      end
    endcase
    if (calc_count == '0) begin
      calc_top = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      wr_idx <= '0;
      wr_num <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q   <= op_t'(op);
            opnd_q <= elem_t'(operand_value);
            state  <= S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          a     <= ram_rdata;
          state <= S_RD2;
        end
        S_RD2: begin
          b     <= ram_rdata;
          state <= S_CALC;
        end
        S_CALC: begin
          wr_addr  <= calc_addr;
          wr_data  <= calc_data;
          wr_num   <= calc_num;
          wr_idx   <= '0;
          count_q  <= calc_count;
          status_q <= calc_status;
          top_q    <= calc_top;
          if (calc_num == 2'd0) begin
            count     <= calc_count;
            done      <= 1'b1;
            top_value <= 32'(calc_top);
            top_valid <= (calc_count != '0);
            depth_now <= 5'(calc_count);
            status    <= calc_status;
            state     <= S_IDLE;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          wr_idx <= wr_idx + 2'd1;
          if (wr_idx == wr_num - 2'd1) begin
            count     <= count_q;
            done      <= 1'b1;
            top_value <= 32'(top_q);
            top_valid <= (count_q != '0);
            depth_now <= 5'(count_q);
            status    <= status_q;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SOE_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken but engine not busy")
  `SOE_ASSERT_NOW(a_valid_count, done, top_valid == (count != '0), "top_valid disagrees with count")
  `SOE_ASSERT_NOW(a_count_on_done, count != $past(count), done, "count moved without a result")
  `SOE_ASSERT_NOW(a_over_cause, done && status == ST_OVER, op_q == OP_PUSH || op_q == OP_OVER, "overflow from an operation that cannot grow")

endmodule

// ===== rtl/core/soe_ram.sv =====
// ----------------------------------------------------------------------------
// soe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module soe_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
